>>> src/assert_macros.svh
// Assertion macros for the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/sts_pkg.sv
// Shared types and constants for the song tone sequencer.
package sts_pkg;

  localparam int TPS_W  = 14;
  localparam int POS_W  = 16;
  localparam int VAL_W  = 16;
  localparam int NOTE_W = 5;
  localparam int PROD_W = VAL_W + TPS_W;
  localparam int CNT_W  = 21;
  localparam int CMP_W  = CNT_W + 10;

  localparam logic [TPS_W-1:0] TPS_RESET = 14'd18;
  localparam logic [VAL_W-1:0] VALUE_MAX = 16'hFFFF;
  localparam logic [9:0]       MS_PER_S  = 10'd1000;

  localparam logic [1:0] KIND_START    = 2'd0;
  localparam logic [1:0] KIND_BYTE     = 2'd1;
  localparam logic [1:0] KIND_TICK     = 2'd2;
  localparam logic [1:0] KIND_SUPPRESS = 2'd3;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FETCH = 2'd1;
  localparam logic [1:0] PH_TONE  = 2'd2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic ADDR_TPS = 1'b0;

  typedef struct packed {
    logic              tone_on;
    logic [NOTE_W-1:0] note_index;
    logic              need_byte;
    logic [POS_W-1:0]  fetch_position;
    logic              song_active;
    logic              was_on;
  } res_t;

endpackage

>>> src/sts_core.sv
// Sequencer state and its registered update for one accepted request.
module sts_core
  import sts_pkg::*;
#(
  parameter int SONG_BYTES = 65536,
  parameter int NOTE_COUNT = 28
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             take,
  input  logic [1:0]       kind,
  input  logic [7:0]       song_byte,
  input  logic [TPS_W-1:0] tps,
  output res_t             res
);

  logic [1:0]        phase_r, phase_nxt;
  logic              song_r, song_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic              seen_r, seen_nxt;
  logic [NOTE_W-1:0] note_r, note_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic              was;

  logic [POS_W-1:0]  pos_inc;
  logic [VAL_W+3:0]  val_acc;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CMP_W-1:0]  cnt_ms;
  logic [PROD_W-1:0] prod_new;

  assign pos_inc  = (pos_r == POS_W'(SONG_BYTES - 1)) ? '0 : pos_r + 1'b1;
  assign val_acc  = {4'd0, val_r} * 20'd10 + 20'(song_byte - CH_ZERO);
  assign cnt_inc  = cnt_r + 1'b1;
  assign cnt_ms   = {10'd0, cnt_inc} * {21'd0, MS_PER_S};
  assign prod_new = {{TPS_W{1'b0}}, val_r} * {{VAL_W{1'b0}}, tps};

  always_comb begin
    phase_nxt = phase_r;
    song_nxt  = song_r;
    pos_nxt   = pos_r;
    val_nxt   = val_r;
    seen_nxt  = seen_r;
    note_nxt  = note_r;
    cnt_nxt   = cnt_r;
    prod_nxt  = prod_r;
    was       = 1'b0;
    unique case (kind)
      KIND_START: begin
        if (phase_r == PH_IDLE) begin
          pos_nxt   = '0;
          song_nxt  = 1'b1;
          phase_nxt = PH_FETCH;
          val_nxt   = '0;
          seen_nxt  = 1'b0;
          note_nxt  = '0;
        end
      end
      KIND_BYTE: begin
        if (phase_r == PH_FETCH) begin
          if (song_byte == CH_NUL) begin
            if (!seen_r) begin
              phase_nxt = PH_IDLE;
              song_nxt  = 1'b0;
              pos_nxt   = '0;
              val_nxt   = '0;
              note_nxt  = '0;
              cnt_nxt   = '0;
              prod_nxt  = '0;
            end else begin
              prod_nxt  = prod_new;
              cnt_nxt   = '0;
              val_nxt   = '0;
              phase_nxt = PH_TONE;
            end
          end else begin
            seen_nxt = 1'b1;
            pos_nxt  = pos_inc;
            if (song_byte >= CH_ZERO && song_byte <= CH_NINE) begin
              val_nxt = (val_acc > {4'd0, VALUE_MAX}) ? VALUE_MAX : val_acc[VAL_W-1:0];
            end else if (song_byte == CH_DASH) begin
              note_nxt = (val_r < VAL_W'(NOTE_COUNT)) ? val_r[NOTE_W-1:0] : '0;
              val_nxt  = '0;
            end else if (song_byte == CH_COMMA) begin
              prod_nxt  = prod_new;
              cnt_nxt   = '0;
              val_nxt   = '0;
              phase_nxt = PH_TONE;
            end
          end
        end
      end
      KIND_TICK: begin
        if (phase_r == PH_TONE) begin
          if (cnt_ms >= {1'b0, prod_r}) begin
            cnt_nxt = '0;
            if (song_r) begin
              phase_nxt = PH_FETCH;
              val_nxt   = '0;
              seen_nxt  = 1'b0;
              note_nxt  = '0;
            end else begin
              phase_nxt = PH_IDLE;
              pos_nxt   = '0;
              val_nxt   = '0;
              seen_nxt  = 1'b0;
              note_nxt  = '0;
              prod_nxt  = '0;
            end
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
      end
      KIND_SUPPRESS: begin
        was       = (phase_r == PH_TONE);
        phase_nxt = PH_IDLE;
        song_nxt  = 1'b0;
        pos_nxt   = '0;
        val_nxt   = '0;
        seen_nxt  = 1'b0;
        note_nxt  = '0;
        cnt_nxt   = '0;
        prod_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      song_r  <= 1'b0;
      pos_r   <= '0;
      val_r   <= '0;
      seen_r  <= 1'b0;
      note_r  <= '0;
      cnt_r   <= '0;
      prod_r  <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      song_r  <= song_nxt;
      pos_r   <= pos_nxt;
      val_r   <= val_nxt;
      seen_r  <= seen_nxt;
      note_r  <= note_nxt;
      cnt_r   <= cnt_nxt;
      prod_r  <= prod_nxt;
    end
  end

  always_comb begin
    res.tone_on        = (phase_nxt == PH_TONE);
    res.note_index     = (phase_nxt == PH_TONE) ? note_nxt : '0;
    res.need_byte      = (phase_nxt == PH_FETCH);
    res.fetch_position = pos_nxt;
    res.song_active    = song_nxt;
    res.was_on         = was;
  end

endmodule

>>> src/sts_obuf.sv
// Two-entry result buffer: an output register backed by a skid register.
module sts_obuf
  import sts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic can_push,
  output logic head_valid,
  input  logic pop_ready,
  output res_t head_data,
  output logic skid_valid
);

  logic hv_r, hv_nxt;
  logic sv_r, sv_nxt;
  res_t head_r, head_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop        = hv_r && pop_ready;
  assign can_push   = !sv_r;
  assign head_valid = hv_r;
  assign head_data  = head_r;
  assign skid_valid = sv_r;

  always_comb begin
    hv_nxt   = hv_r;
    sv_nxt   = sv_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    if (pop) begin
      if (sv_r) begin
        head_nxt = skid_r;
        sv_nxt   = 1'b0;
      end else if (push) begin
        head_nxt = push_data;
      end else begin
        hv_nxt = 1'b0;
      end
    end else if (push) begin
      if (!hv_r) begin
        head_nxt = push_data;
        hv_nxt   = 1'b1;
      end else begin
        skid_nxt = push_data;
        sv_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hv_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      hv_r <= hv_nxt;
      sv_r <= sv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

endmodule

>>> src/song_tone_sequencer.sv
// Each accepted result is registered into the output register, or the skid register if one waits.
// One request per cycle while the skid register is empty; the state update is a single registered pass.
// A two-entry result buffer keeps requests flowing while a result waits to be taken.
// Reset is synchronous and active low: idle, position 0, tick rate 18.
// Top level of the song tone sequencer with its configuration port.
module song_tone_sequencer
  import sts_pkg::*;
#(
  parameter int SONG_BYTES = 65536,
  parameter int NOTE_COUNT = 28
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_song_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_tone_on,
  output logic [NOTE_W-1:0] out_note_index,
  output logic              out_need_byte,
  output logic [POS_W-1:0]  out_fetch_position,
  output logic              out_song_active,
  output logic              out_was_on,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

`include "assert_macros.svh"

  logic [TPS_W-1:0] tps_r;
  logic             take;
  logic             skid_valid;
  res_t             res;
  res_t             head;

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_TPS) ? {{(32 - TPS_W){1'b0}}, tps_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_TPS) begin
      tps_r <= pwdata[TPS_W-1:0];
    end
  end

  assign take = in_valid && in_ready;

  sts_core #(
    .SONG_BYTES(SONG_BYTES),
    .NOTE_COUNT(NOTE_COUNT)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .kind     (in_kind),
    .song_byte(in_song_byte),
    .tps      (tps_r),
    .res      (res)
  );

  sts_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take),
    .push_data (res),
    .can_push  (in_ready),
    .head_valid(out_valid),
    .pop_ready (out_ready),
    .head_data (head),
    .skid_valid(skid_valid)
  );

  assign out_tone_on        = head.tone_on;
  assign out_note_index     = head.note_index;
  assign out_need_byte      = head.need_byte;
  assign out_fetch_position = head.fetch_position;
  assign out_song_active    = head.song_active;
  assign out_was_on         = head.was_on;

  `ASSERT_IMPL(a_skid_has_head, skid_valid, out_valid)
  `ASSERT_NEXT(a_take_fills, take, out_valid)
  `ASSERT_IMPL(a_tone_in_song, out_valid && (out_tone_on || out_need_byte), out_song_active)
  `ASSERT_IMPL(a_one_phase, out_valid, !(out_tone_on && out_need_byte))

endmodule

>>> sim/song_tone_sequencer_test.sv
// Self-checking testbench for the song tone sequencer with directed and random songs.
module song_tone_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sts_pkg::*;

  localparam int NOTE_LIMIT = 28;
  localparam int SONG_SPACE = 65536;
  localparam int RANDOM_TARGET = 1550;
  localparam int RATE_PHASES = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  typedef struct {
    logic [1:0]        phase;
    logic              song_on;
    logic [POS_W-1:0]  pos;
    logic [VAL_W-1:0]  value;
    logic              begun;
    logic [NOTE_W-1:0] note;
    logic [31:0]       count;
    logic [31:0]       limit;
    logic [TPS_W-1:0]  tps;
  } player_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] song_byte;
  } request_t;

  typedef enum logic [1:0] {STALL_NONE, STALL_COIN, STALL_THIRD, STALL_RARE} stall_mode_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_kind = KIND_START;
  logic [7:0]        in_song_byte = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_tone_on;
  logic [NOTE_W-1:0] out_note_index;
  logic              out_need_byte;
  logic [POS_W-1:0]  out_fetch_position;
  logic              out_song_active;
  logic              out_was_on;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic              paddr = ADDR_TPS;
  logic [31:0]       pwdata = 32'h0;
  logic [31:0]       prdata;
  logic              pready;

  request_t      pending_requests[$];
  res_t          expected_results[$];
  player_state_t plan_st;
  player_state_t model_st;
  logic [7:0]    song_mem [0:SONG_SPACE-1];

  int unsigned issued_total = 0;
  int unsigned accepted_total = 0;
  int unsigned checked_total = 0;
  int unsigned error_total = 0;
  int unsigned songs_total = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned stall_left = 0;
  int unsigned stall_phase = 0;
  stall_mode_t stall_mode = STALL_NONE;

  song_tone_sequencer uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_kind(in_kind),
    .in_song_byte(in_song_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_tone_on(out_tone_on),
    .out_note_index(out_note_index),
    .out_need_byte(out_need_byte),
    .out_fetch_position(out_fetch_position),
    .out_song_active(out_song_active),
    .out_was_on(out_was_on),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic void open_pair(inout player_state_t st);
    st.phase = PH_FETCH;
    st.value = '0;
    st.begun = 1'b0;
    st.note = '0;
  endfunction

  function automatic void halt_player(inout player_state_t st);
    st.phase = PH_IDLE;
    st.song_on = 1'b0;
    st.pos = '0;
    st.value = '0;
    st.begun = 1'b0;
    st.note = '0;
    st.count = '0;
    st.limit = '0;
  endfunction

  function automatic void sound_tone(inout player_state_t st);
    logic [63:0] ticks;
    ticks = (64'(st.value) * 64'(st.tps) + 64'(MS_PER_S) - 64'd1) / 64'(MS_PER_S);
    st.limit = ticks[31:0];
    st.count = '0;
    st.value = '0;
    st.phase = PH_TONE;
  endfunction

  function automatic res_t player_step(inout player_state_t st, input request_t rq);
    res_t        r;
    logic        was;
    int unsigned acc;
    was = 1'b0;
    case (rq.kind)
      KIND_START: begin
        if (st.phase == PH_IDLE) begin
          st.pos = '0;
          st.song_on = 1'b1;
          open_pair(st);
        end
      end
      KIND_BYTE: begin
        if (st.phase == PH_FETCH) begin
          if (rq.song_byte == CH_NUL) begin
            if (!st.begun) halt_player(st);
            else sound_tone(st);
          end else begin
            st.begun = 1'b1;
            st.pos = st.pos + 1'b1;
            if (rq.song_byte >= CH_ZERO && rq.song_byte <= CH_NINE) begin
              acc = 32'(st.value) * 10 + 32'(rq.song_byte - CH_ZERO);
              st.value = (acc > 32'(VALUE_MAX)) ? VALUE_MAX : acc[VAL_W-1:0];
            end else if (rq.song_byte == CH_DASH) begin
              st.note = (st.value < NOTE_LIMIT) ? st.value[NOTE_W-1:0] : '0;
              st.value = '0;
            end else if (rq.song_byte == CH_COMMA) begin
              sound_tone(st);
            end
          end
        end
      end
      KIND_TICK: begin
        if (st.phase == PH_TONE) begin
          if (st.count != '1) st.count = st.count + 1;
          if (st.count >= st.limit) begin
            st.count = '0;
            if (st.song_on) open_pair(st);
            else halt_player(st);
          end
        end
      end
      KIND_SUPPRESS: begin
        was = (st.phase == PH_TONE);
        halt_player(st);
      end
    endcase
    r.tone_on = (st.phase == PH_TONE);
    r.note_index = r.tone_on ? st.note : '0;
    r.need_byte = (st.phase == PH_FETCH);
    r.fetch_position = st.pos;
    r.song_active = st.song_on;
    r.was_on = was;
    return r;
  endfunction

  function automatic void issue_request(input logic [1:0] kind, input logic [7:0] b);
    request_t rq;
    rq.kind = kind;
    rq.song_byte = b;
    void'(player_step(plan_st, rq));
    pending_requests.push_back(rq);
    issued_total++;
  endfunction

  function automatic void feed_text(input string s);
    for (int i = 0; i < s.len(); i++) issue_request(KIND_BYTE, s[i]);
  endfunction

  function automatic void put_byte(inout int unsigned at, input logic [7:0] b);
    song_mem[at] = b;
    at++;
  endfunction

  function automatic void put_text(inout int unsigned at, input string s);
    for (int i = 0; i < s.len(); i++) put_byte(at, s[i]);
  endfunction

  function automatic void compose_song();
    int unsigned at;
    int unsigned pairs;
    int unsigned max_ms;
    int unsigned pick;
    string       pair_text;
    at = 0;
    pairs = $urandom_range(1, 6);
    max_ms = 30000 / int'(plan_st.tps);
    for (int p = 0; p < pairs; p++) begin
      if ($urandom_range(0, 99) < 8) put_byte(at, 8'($urandom_range(1, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 70) pair_text = $sformatf("%0d-", $urandom_range(0, 27));
      else if (pick < 82) pair_text = $sformatf("%0d-", $urandom_range(28, 99999));
      else if (pick < 92) pair_text = $sformatf("%03d-", $urandom_range(0, 40));
      else pair_text = "";
      if ($urandom_range(0, 99) < 4) begin
        pair_text = {pair_text, $sformatf("%0d", $urandom_range(65536, 999999))};
      end else begin
        pair_text = {pair_text, $sformatf("%0d", $urandom_range(0, max_ms))};
      end
      put_text(at, pair_text);
      if (p != pairs - 1 || $urandom_range(0, 9) != 0) put_byte(at, CH_COMMA);
    end
    put_byte(at, CH_NUL);
  endfunction

  // Follows the song as the block will fetch it, with ignored requests and cutting suppressions mixed in.
  function automatic void play_song(input int unsigned budget, input int unsigned cut_per_mille,
                                    inout int unsigned spent);
    int unsigned used;
    used = 1;
    issue_request(KIND_START, 8'($urandom));
    while (plan_st.phase != PH_IDLE) begin
      if (used >= budget || $urandom_range(0, 999) < cut_per_mille) begin
        issue_request(KIND_SUPPRESS, 8'($urandom));
        used++;
      end else if ($urandom_range(0, 99) < 6) begin
        if (plan_st.phase == PH_FETCH) begin
          issue_request($urandom_range(0, 1) ? KIND_START : KIND_TICK, 8'($urandom));
        end else begin
          issue_request($urandom_range(0, 1) ? KIND_START : KIND_BYTE, 8'($urandom));
        end
      end else if (plan_st.phase == PH_FETCH) begin
        issue_request(KIND_BYTE, song_mem[plan_st.pos]);
        used++;
      end else begin
        issue_request(KIND_TICK, 8'($urandom));
        used++;
      end
    end
    if ($urandom_range(0, 3) == 0) begin
      issue_request($urandom_range(0, 1) ? KIND_TICK : KIND_BYTE, 8'($urandom));
    end
    spent += used;
    songs_total++;
  endfunction

  task automatic settle();
    while (checked_total != issued_total) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_tick_rate(input logic [TPS_W-1:0] rate);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_TPS;
    pwdata <= 32'(rate);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    plan_st.tps = rate;
    model_st.tps = rate;
  endtask

  always @(posedge clk) begin : drive_requests
    request_t rq;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        rq.kind = in_kind;
        rq.song_byte = in_song_byte;
        expected_results.push_back(player_step(model_st, rq));
        accepted_total++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pending_requests.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          rq = pending_requests.pop_front();
          in_valid <= 1'b1;
          in_kind <= rq.kind;
          in_song_byte <= rq.song_byte;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : pace_results
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      stall_phase++;
      case (stall_mode)
        STALL_NONE: out_ready <= 1'b1;
        STALL_COIN: out_ready <= 1'($urandom_range(0, 1));
        STALL_THIRD: out_ready <= (stall_phase % 3 == 0);
        default: out_ready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_results
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("result arrived with no request outstanding");
        error_total++;
      end else begin
        want = expected_results.pop_front();
        checked_total++;
        if (out_tone_on !== want.tone_on) begin
          $error("tone_on: expected %0d, got %0d", want.tone_on, out_tone_on);
          error_total++;
        end
        if (out_note_index !== want.note_index) begin
          $error("note_index: expected %0d, got %0d", want.note_index, out_note_index);
          error_total++;
        end
        if (out_need_byte !== want.need_byte) begin
          $error("need_byte: expected %0d, got %0d", want.need_byte, out_need_byte);
          error_total++;
        end
        if (out_fetch_position !== want.fetch_position) begin
          $error("fetch_position: expected %0d, got %0d", want.fetch_position,
                 out_fetch_position);
          error_total++;
        end
        if (out_song_active !== want.song_active) begin
          $error("song_active: expected %0d, got %0d", want.song_active, out_song_active);
          error_total++;
        end
        if (out_was_on !== want.was_on) begin
          $error("was_on: expected %0d, got %0d", want.was_on, out_was_on);
          error_total++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: nothing moved for %0d cycles", quiet_cycles);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned      spent;
    logic [TPS_W-1:0] rate;
    for (int i = 0; i < SONG_SPACE; i++) song_mem[i] = CH_NUL;
    halt_player(plan_st);
    plan_st.tps = TPS_RESET;
    model_st = plan_st;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    issue_request(KIND_TICK, 8'hFF);
    issue_request(KIND_BYTE, 8'hFF);
    issue_request(KIND_SUPPRESS, 8'h00);
    issue_request(KIND_START, 8'hFF);
    issue_request(KIND_START, 8'h00);
    issue_request(KIND_TICK, 8'h00);
    feed_text("27-1,");
    issue_request(KIND_TICK, 8'hFF);
    feed_text("99-0,");
    issue_request(KIND_TICK, 8'h00);
    issue_request(KIND_BYTE, 8'hFF);
    feed_text("5");
    issue_request(KIND_BYTE, CH_NUL);
    issue_request(KIND_SUPPRESS, 8'hFF);
    issue_request(KIND_START, 8'h00);
    issue_request(KIND_BYTE, CH_NUL);

    for (int p = 0; p < RATE_PHASES; p++) begin
      case (p % 4)
        0: rate = 14'd10000;
        1: rate = 14'd1;
        default: rate = 14'($urandom_range(1, 10000));
      endcase
      write_tick_rate(rate);
      spent = 0;
      while (spent < RANDOM_TARGET / RATE_PHASES) begin
        compose_song();
        play_song(150, 10, spent);
      end
    end

    settle();
    $display("Sent %0d requests over %0d songs at tick rates from 1 to 10000.",
             accepted_total, songs_total);
    $display("Checked %0d results and found %0d mismatches.", checked_total, error_total);
    if (error_total == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+src
src/sts_pkg.sv
src/sts_core.sv
src/sts_obuf.sv
src/song_tone_sequencer.sv
sim/song_tone_sequencer_test.sv
